// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the mouse report encoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ----- hdl/mre_pkg.sv -----
// ----------------------------------------------------------------------------
// mre_pkg
// Shared codes, report descriptor type and decimal helpers for the mouse
// report encoder.
// ----------------------------------------------------------------------------
package mre_pkg;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_TRACKING_MODE   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPORT_ENCODING = 1'b1;

  // Tracking modes
  localparam logic [2:0] TRK_NONE   = 3'd0;
  localparam logic [2:0] TRK_X10    = 3'd1;
  localparam logic [2:0] TRK_NORMAL = 3'd2;
  localparam logic [2:0] TRK_BUTTON = 3'd3;
  localparam logic [2:0] TRK_ANY    = 3'd4;

  // Report encodings
  localparam logic [1:0] ENC_SIMPLE = 2'd0;
  localparam logic [1:0] ENC_UTF8   = 2'd1;
  localparam logic [1:0] ENC_SGR    = 2'd2;
  localparam logic [1:0] ENC_URXVT  = 2'd3;

  // Event kinds
  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_MOTION  = 2'd2;

  // Characters of the report
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_UPPER_M  = 8'h4D;
  localparam logic [7:0] CH_LOWER_M  = 8'h6D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CODE_OFFSET = 8'd32;

  // Event code bits
  localparam logic [6:0] CODE_NONE   = 7'd3;
  localparam logic [6:0] CODE_WHEEL4 = 7'd64;
  localparam logic [6:0] CODE_WHEEL5 = 7'd65;
  localparam logic [6:0] BIT_SHIFT   = 7'd4;
  localparam logic [6:0] BIT_ALT     = 7'd8;
  localparam logic [6:0] BIT_CTRL    = 7'd16;
  localparam logic [6:0] BIT_MOTION  = 7'd32;

  // Hundreds, tens, units in slots 0, 1, 2
  typedef logic [2:0][3:0] dec_digits_t;

  // One report, as the back end replays it
  typedef struct packed {
    logic [1:0]              enc;
    logic [2:0][7:0]         raw;     // offset bytes for simple/utf8
    logic [2:0][2:0][3:0]    dig;     // decimal fields for sgr/urxvt
    logic [2:0][1:0]         start;   // first digit slot printed per field
    logic                    lower;   // sgr final byte is 'm'
  } desc_t;

  typedef enum logic [2:0] {
    ST_ESC,
    ST_BRACKET,
    ST_PREFIX,
    ST_FIELD,
    ST_SEP,
    ST_FINAL
  } seq_state_t;

  // Split a value up to 299 into decimal digits.
  function automatic dec_digits_t to_bcd(input logic [8:0] v);
    logic [1:0]  h;
    logic [6:0]  r;
    logic [13:0] prod;
    logic [3:0]  t;
    logic [6:0]  u;
    dec_digits_t d;
    if (v >= 9'd200) begin
      h = 2'd2;
      r = 7'(v - 9'd200);
    end else if (v >= 9'd100) begin
      h = 2'd1;
      r = 7'(v - 9'd100);
    end else begin
      h = 2'd0;
      r = v[6:0];
    end
    // r * 103 / 1024 equals r / 10 for r below 100
    prod = 14'(r) * 14'd103;
    t    = prod[13:10];
    u    = 7'(r - 7'({3'b000, t} * 7'd10));
    d[0] = {2'b00, h};
    d[1] = t;
    d[2] = u[3:0];
    return d;
  endfunction

  // Leading digit slot, so no leading zeros are sent.
  function automatic logic [1:0] first_digit(input logic [8:0] v);
    if (v >= 9'd100) begin
      return 2'd0;
    end else if (v >= 9'd10) begin
      return 2'd1;
    end
    return 2'd2;
  endfunction

endpackage

// ----- hdl/mouse_report_encoder.sv -----
// ----------------------------------------------------------------------------
// mouse_report_encoder: xterm mouse tracking report encoder.
// Accepted events are queued; the output sequencer sends one byte per cycle
// through the output register while out_ready holds. A report is 6 bytes
// (simple/utf8), up to 14 (urxvt) or 15 (sgr); reports follow back to back.
// Reset: tracking mode none, simple encoding, queue and output register empty.
// ----------------------------------------------------------------------------
module mouse_report_encoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mre_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mre_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      event_kind,
  input  logic [7:0]                      row,
  input  logic [7:0]                      column,
  input  logic [2:0]                      button,
  input  logic [3:0]                      modifiers,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic                            last_byte
);

  logic           push, pop, q_full, head_valid;
  mre_pkg::desc_t push_desc, head_desc;

  mre_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .event_kind (event_kind),
    .row        (row),
    .column     (column),
    .button     (button),
    .modifiers  (modifiers),
    .q_full     (q_full),
    .push       (push),
    .push_desc  (push_desc)
  );

  mre_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .full       (q_full)
  );

  mre_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last_byte  (last_byte)
  );

endmodule

// ----- hdl/mre_front.sv -----
// ----------------------------------------------------------------------------
// mre_front
// Holds the configuration, filters pointer events by tracking mode, builds
// the event code and prepares a report descriptor for the queue.
// ----------------------------------------------------------------------------
module mre_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mre_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mre_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         event_kind,
  input  logic [7:0]                         row,
  input  logic [7:0]                         column,
  input  logic [2:0]                         button,
  input  logic [3:0]                         modifiers,
  input  logic                               q_full,
  output logic                               push,
  output mre_pkg::desc_t                     push_desc
);

  logic [2:0] tracking_mode;
  logic [1:0] report_encoding;

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_mode   <= mre_pkg::TRK_NONE;
      report_encoding <= mre_pkg::ENC_SIMPLE;
    end else if (cfg_write) begin
      case (cfg_index)
        mre_pkg::REG_TRACKING_MODE:   tracking_mode   <= cfg_data;
        mre_pkg::REG_REPORT_ENCODING: report_encoding <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic       is_press, is_rel, is_mot;
  logic       mode_ok, kind_ok, x10_ok, mot_ok, pass;
  logic [6:0] code;
  logic [8:0] x, y;
  logic [7:0] code_off;
  logic [2:0][8:0] dec_val;

  assign is_press = (event_kind == mre_pkg::KIND_PRESS);
  assign is_rel   = (event_kind == mre_pkg::KIND_RELEASE);
  assign is_mot   = (event_kind == mre_pkg::KIND_MOTION);

  assign mode_ok = (tracking_mode == mre_pkg::TRK_X10) ||
                   (tracking_mode == mre_pkg::TRK_NORMAL) ||
                   (tracking_mode == mre_pkg::TRK_BUTTON) ||
                   (tracking_mode == mre_pkg::TRK_ANY);
  assign kind_ok = is_press || is_rel || is_mot;
  assign x10_ok  = (tracking_mode != mre_pkg::TRK_X10) || (is_press && (button != 3'd0));
  assign mot_ok  = !is_mot || (tracking_mode == mre_pkg::TRK_ANY) ||
                   ((tracking_mode == mre_pkg::TRK_BUTTON) && (button != 3'd0));
  assign pass    = mode_ok && kind_ok && x10_ok && mot_ok;

  always_comb begin
    if (tracking_mode == mre_pkg::TRK_X10) begin
      code = {4'b0000, 3'(button - 3'd1)};
    end else begin
      if ((button == 3'd0) || (is_rel && (report_encoding != mre_pkg::ENC_SGR))) begin
        code = mre_pkg::CODE_NONE;
      end else begin
        case (button)
          3'd1:    code = 7'd0;
          3'd2:    code = 7'd1;
          3'd3:    code = 7'd2;
          3'd4:    code = mre_pkg::CODE_WHEEL4;
          3'd5:    code = mre_pkg::CODE_WHEEL5;
          default: code = 7'd0;
        endcase
      end
      if (modifiers[1])                 code = code | mre_pkg::BIT_SHIFT;
      if (modifiers[2] || modifiers[3]) code = code | mre_pkg::BIT_ALT;
      if (modifiers[0])                 code = code | mre_pkg::BIT_CTRL;
      if (is_mot)                       code = code | mre_pkg::BIT_MOTION;
    end
  end

  assign x        = {1'b0, column} + 9'd1;
  assign y        = {1'b0, row} + 9'd1;
  assign code_off = {1'b0, code} + mre_pkg::CODE_OFFSET;

  // SGR prints the plain code and full coordinates; URXVT the offset code and
  // coordinates wrapped to a byte.
  always_comb begin
    if (report_encoding == mre_pkg::ENC_SGR) begin
      dec_val[0] = {2'b00, code};
      dec_val[1] = x;
      dec_val[2] = y;
    end else begin
      dec_val[0] = {1'b0, code_off};
      dec_val[1] = {1'b0, x[7:0]};
      dec_val[2] = {1'b0, y[7:0]};
    end
  end

  always_comb begin
    push_desc.enc    = report_encoding;
    push_desc.raw[0] = code_off;
    push_desc.raw[1] = x[7:0] + mre_pkg::CODE_OFFSET;
    push_desc.raw[2] = y[7:0] + mre_pkg::CODE_OFFSET;
    for (int i = 0; i < 3; i++) begin
      push_desc.dig[i]   = mre_pkg::to_bcd(dec_val[i]);
      push_desc.start[i] = mre_pkg::first_digit(dec_val[i]);
    end
    push_desc.lower = !(is_press || (is_mot && (button != 3'd0)));
  end

  assign in_ready = !q_full;
  // Suppressed events are taken and dropped here.
  assign push     = in_valid && in_ready && pass;

endmodule

// ----- hdl/mre_queue.sv -----
// ----------------------------------------------------------------------------
// mre_queue
// Two-entry queue of report descriptors between front and back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mre_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mre_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           head_valid,
  output mre_pkg::desc_t head_desc,
  output logic           full
);

  mre_pkg::desc_t entry [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign head_valid = (count != 2'd0);
  assign head_desc  = entry[rd_ptr];
  assign full       = (count == 2'd2);

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && (count == 2'd2))
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && (count == 2'd0))

endmodule

// ----- hdl/mre_back.sv -----
// ----------------------------------------------------------------------------
// mre_back
// Byte sequencer: walks the head descriptor and sends one report byte per
// transfer through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mre_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  mre_pkg::desc_t head_desc,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           last_byte
);

  mre_pkg::seq_state_t st, st_next;
  logic [1:0] fld, fld_next, fld_inc;
  logic [1:0] dig, dig_next;
  logic [7:0] byte_val;
  logic       byte_last;
  logic       is_simple, is_sgr, is_urxvt;
  logic       load, emit;

  assign is_simple = (head_desc.enc == mre_pkg::ENC_SIMPLE) ||
                     (head_desc.enc == mre_pkg::ENC_UTF8);
  assign is_sgr    = (head_desc.enc == mre_pkg::ENC_SGR);
  assign is_urxvt  = (head_desc.enc == mre_pkg::ENC_URXVT);
  assign fld_inc   = fld + 2'd1;

  always_comb begin
    st_next   = st;
    fld_next  = fld;
    dig_next  = dig;
    byte_val  = mre_pkg::CH_ESC;
    byte_last = 1'b0;
    case (st)
      mre_pkg::ST_ESC: begin
        byte_val = mre_pkg::CH_ESC;
        st_next  = mre_pkg::ST_BRACKET;
      end
      mre_pkg::ST_BRACKET: begin
        byte_val = mre_pkg::CH_LBRACKET;
        fld_next = 2'd0;
        dig_next = head_desc.start[0];
        st_next  = is_urxvt ? mre_pkg::ST_FIELD : mre_pkg::ST_PREFIX;
      end
      mre_pkg::ST_PREFIX: begin
        byte_val = is_sgr ? mre_pkg::CH_LT : mre_pkg::CH_UPPER_M;
        fld_next = 2'd0;
        dig_next = head_desc.start[0];
        st_next  = mre_pkg::ST_FIELD;
      end
      mre_pkg::ST_FIELD: begin
        if (is_simple) begin
          byte_val = head_desc.raw[fld];
          if (fld == 2'd2) begin
            byte_last = 1'b1;
            fld_next  = 2'd0;
            st_next   = mre_pkg::ST_ESC;
          end else begin
            fld_next = fld_inc;
          end
        end else begin
          byte_val = mre_pkg::CH_ZERO + {4'b0000, head_desc.dig[fld][dig]};
          if (dig == 2'd2) begin
            st_next = (fld == 2'd2) ? mre_pkg::ST_FINAL : mre_pkg::ST_SEP;
          end else begin
            dig_next = dig + 2'd1;
          end
        end
      end
      mre_pkg::ST_SEP: begin
        byte_val = mre_pkg::CH_SEMI;
        fld_next = fld_inc;
        dig_next = head_desc.start[fld_inc];
        st_next  = mre_pkg::ST_FIELD;
      end
      mre_pkg::ST_FINAL: begin
        byte_val  = (is_sgr && head_desc.lower) ? mre_pkg::CH_LOWER_M : mre_pkg::CH_UPPER_M;
        byte_last = 1'b1;
        fld_next  = 2'd0;
        dig_next  = 2'd0;
        st_next   = mre_pkg::ST_ESC;
      end
      default: begin
        st_next  = mre_pkg::ST_ESC;
        fld_next = 2'd0;
        dig_next = 2'd0;
      end
    endcase
  end

  // Advance whenever a descriptor is waiting and the output register is free or being drained.
  assign load = !out_valid || out_ready;
  assign emit = load && head_valid;
  assign pop  = emit && byte_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= mre_pkg::ST_ESC;
      fld       <= 2'd0;
      dig       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        st        <= st_next;
        fld       <= fld_next;
        dig       <= dig_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= byte_val;
      last_byte <= byte_last;
    end
  end

  `ASSERT_IMPL(a_last_rewinds, clk, rst, out_valid && last_byte,
               (st == mre_pkg::ST_ESC) && (fld == 2'd0))

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Mouse report encoder testbench
// Sends pointer events through the valid/ready input under every tracking
// mode and report encoding, predicts each escape sequence byte by byte and
// compares every output transfer against the oldest predicted byte, with
// random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 6;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] TRK_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] TRK_UNKNOWN_HI = 3'd7;

  localparam logic [2:0] BTN_NONE   = 3'd0;
  localparam logic [2:0] BTN_LEFT   = 3'd1;
  localparam logic [2:0] BTN_MIDDLE = 3'd2;
  localparam logic [2:0] BTN_RIGHT  = 3'd3;
  localparam logic [2:0] WHEEL_UP   = 3'd4;
  localparam logic [2:0] WHEEL_DOWN = 3'd5;
  localparam logic [2:0] BTN_EXTRA6 = 3'd6;
  localparam logic [2:0] BTN_EXTRA7 = 3'd7;

  localparam logic [3:0] MOD_NONE  = 4'd0;
  localparam logic [3:0] MOD_CTRL  = 4'd1;
  localparam logic [3:0] MOD_SHIFT = 4'd2;
  localparam logic [3:0] MOD_ALT   = 4'd4;
  localparam logic [3:0] MOD_META  = 4'd8;
  localparam logic [3:0] MOD_ALL   = 4'd15;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } report_byte_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_write;
  logic [mre_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [mre_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  logic [1:0]                      event_kind;
  logic [7:0]                      row;
  logic [7:0]                      column;
  logic [2:0]                      button;
  logic [3:0]                      modifiers;
  logic                            out_valid;
  logic                            out_ready;
  logic [7:0]                      out_byte;
  logic                            last_byte;

  // Shadow copy of the block's registers
  logic [2:0] mode_setting;
  logic [1:0] encoding_setting;

  logic [7:0]   report_text[$];
  report_byte_t pending_bytes[$];

  bit in_idle_on;
  bit out_idle_on;
  int errors;
  int cycle_count;
  int events_sent;
  int events_reported;
  int bytes_checked;

  mouse_report_encoder dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .event_kind (event_kind),
    .row        (row),
    .column     (column),
    .button     (button),
    .modifiers  (modifiers),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last_byte  (last_byte)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Print a value in decimal without leading zeros.
  function automatic void append_decimal(input int unsigned v);
    if (v >= 100) begin
      report_text.push_back(8'(mre_pkg::CH_ZERO + v / 100));
    end
    if (v >= 10) begin
      report_text.push_back(8'(mre_pkg::CH_ZERO + (v / 10) % 10));
    end
    report_text.push_back(8'(mre_pkg::CH_ZERO + v % 10));
  endfunction

  // Build the escape sequence for one event and queue its bytes.
  function automatic int encode_mouse_report(input logic [1:0] kind, input logic [7:0] r,
                                             input logic [7:0] c, input logic [2:0] btn,
                                             input logic [3:0] mods);
    logic [8:0] x;
    logic [8:0] y;
    logic [7:0] code;
    report_byte_t entry;
    x = {1'b0, c} + 9'd1;
    y = {1'b0, r} + 9'd1;
    report_text.delete();
    if (mode_setting == mre_pkg::TRK_NONE || mode_setting > mre_pkg::TRK_ANY ||
        kind == KIND_UNUSED) begin
      return 0;
    end
    if (mode_setting == mre_pkg::TRK_X10 &&
        (btn == BTN_NONE || kind == mre_pkg::KIND_RELEASE)) begin
      return 0;
    end
    if (kind == mre_pkg::KIND_MOTION && mode_setting != mre_pkg::TRK_BUTTON &&
        mode_setting != mre_pkg::TRK_ANY) begin
      return 0;
    end
    if (kind == mre_pkg::KIND_MOTION && mode_setting == mre_pkg::TRK_BUTTON &&
        btn == BTN_NONE) begin
      return 0;
    end

    if (mode_setting == mre_pkg::TRK_X10) begin
      code = 8'(btn) - 8'd1;
    end else begin
      if (btn == BTN_NONE ||
          (kind == mre_pkg::KIND_RELEASE && encoding_setting != mre_pkg::ENC_SGR)) begin
        code = 8'(mre_pkg::CODE_NONE);
      end else begin
        case (btn)
          BTN_LEFT:   code = 8'd0;
          BTN_MIDDLE: code = 8'd1;
          BTN_RIGHT:  code = 8'd2;
          WHEEL_UP:   code = 8'(mre_pkg::CODE_WHEEL4);
          WHEEL_DOWN: code = 8'(mre_pkg::CODE_WHEEL5);
          default:    code = 8'd0;
        endcase
      end
      if (mods[1]) code |= 8'(mre_pkg::BIT_SHIFT);
      if (mods[3:2] != 2'b00) code |= 8'(mre_pkg::BIT_ALT);
      if (mods[0]) code |= 8'(mre_pkg::BIT_CTRL);
      if (kind == mre_pkg::KIND_MOTION) code |= 8'(mre_pkg::BIT_MOTION);
    end

    report_text.push_back(mre_pkg::CH_ESC);
    report_text.push_back(mre_pkg::CH_LBRACKET);
    case (encoding_setting)
      mre_pkg::ENC_SIMPLE, mre_pkg::ENC_UTF8: begin
        report_text.push_back(mre_pkg::CH_UPPER_M);
        report_text.push_back(8'(mre_pkg::CODE_OFFSET + code));
        report_text.push_back(8'(mre_pkg::CODE_OFFSET + x));
        report_text.push_back(8'(mre_pkg::CODE_OFFSET + y));
      end
      mre_pkg::ENC_SGR: begin
        report_text.push_back(mre_pkg::CH_LT);
        append_decimal(code);
        report_text.push_back(mre_pkg::CH_SEMI);
        append_decimal(x);
        report_text.push_back(mre_pkg::CH_SEMI);
        append_decimal(y);
        report_text.push_back((kind == mre_pkg::KIND_PRESS ||
                               (kind == mre_pkg::KIND_MOTION && btn != BTN_NONE))
                              ? mre_pkg::CH_UPPER_M : mre_pkg::CH_LOWER_M);
      end
      default: begin
        append_decimal(8'(mre_pkg::CODE_OFFSET + code));
        report_text.push_back(mre_pkg::CH_SEMI);
        append_decimal(x[7:0]);
        report_text.push_back(mre_pkg::CH_SEMI);
        append_decimal(y[7:0]);
        report_text.push_back(mre_pkg::CH_UPPER_M);
      end
    endcase

    foreach (report_text[i]) begin
      entry.value = report_text[i];
      entry.last  = (i == report_text.size() - 1);
      pending_bytes.push_back(entry);
    end
    return report_text.size();
  endfunction

  task automatic send_event(input logic [1:0] kind, input logic [7:0] r, input logic [7:0] c,
                            input logic [2:0] btn, input logic [3:0] mods);
    int gap;
    int n;
    gap = in_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    event_kind <= kind;
    row        <= r;
    column     <= c;
    button     <= btn;
    modifiers  <= mods;
    do @(posedge clk); while (!(in_valid && in_ready));
    n = encode_mouse_report(kind, r, c, btn, mods);
    events_sent++;
    if (n > 0) events_reported++;
  endtask

  // Drop valid and hold until every predicted byte has left the block.
  task automatic wait_reports_done();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [mre_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [mre_pkg::CFG_DATA_W-1:0] data);
    wait_reports_done();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == mre_pkg::REG_TRACKING_MODE) mode_setting = data;
    else encoding_setting = data[1:0];
  endtask

  // Output side: while out_idle_on is set, stall a random number of cycles before each byte.
  initial begin : drive_out_ready
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = out_idle_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin : check_bytes
    report_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected transfer: out_byte %02h last_byte %0b", out_byte, last_byte);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (out_byte !== want.value) begin
          $error("out_byte: expected %02h, got %02h", want.value, out_byte);
          errors++;
        end
        if (last_byte !== want.last) begin
          $error("last_byte: expected %0b, got %0b", want.last, last_byte);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_state();
    // Tracking is off after reset, so this press is swallowed.
    send_event(mre_pkg::KIND_PRESS, 8'd10, 8'd20, BTN_LEFT, MOD_NONE);
  endtask

  task automatic test_normal_simple();
    write_register(mre_pkg::REG_TRACKING_MODE, mre_pkg::TRK_NORMAL);
    send_event(mre_pkg::KIND_PRESS, 8'd0, 8'd0, BTN_LEFT, MOD_NONE);
    // column 223 wraps the offset byte to zero
    send_event(mre_pkg::KIND_RELEASE, 8'd255, 8'd223, BTN_LEFT, MOD_ALL);
    send_event(mre_pkg::KIND_PRESS, 8'd5, 8'd6, WHEEL_UP, MOD_SHIFT);
    send_event(mre_pkg::KIND_PRESS, 8'd254, 8'd255, WHEEL_DOWN, MOD_CTRL);
    send_event(mre_pkg::KIND_PRESS, 8'd100, 8'd99, BTN_EXTRA7, MOD_META);
    send_event(mre_pkg::KIND_MOTION, 8'd1, 8'd1, BTN_MIDDLE, MOD_NONE);
    send_event(KIND_UNUSED, 8'd1, 8'd1, BTN_LEFT, MOD_NONE);
  endtask

  task automatic test_x10_utf8();
    write_register(mre_pkg::REG_TRACKING_MODE, mre_pkg::TRK_X10);
    write_register(mre_pkg::REG_REPORT_ENCODING, {1'b1, mre_pkg::ENC_UTF8});
    send_event(mre_pkg::KIND_PRESS, 8'd222, 8'd222, BTN_RIGHT, MOD_ALL);
    send_event(mre_pkg::KIND_PRESS, 8'd3, 8'd4, BTN_NONE, MOD_NONE);
    send_event(mre_pkg::KIND_RELEASE, 8'd3, 8'd4, BTN_LEFT, MOD_NONE);
    send_event(mre_pkg::KIND_PRESS, 8'd7, 8'd8, BTN_EXTRA6, MOD_SHIFT);
  endtask

  task automatic test_motion_sgr();
    write_register(mre_pkg::REG_TRACKING_MODE, mre_pkg::TRK_BUTTON);
    write_register(mre_pkg::REG_REPORT_ENCODING, mre_pkg::ENC_SGR);
    send_event(mre_pkg::KIND_MOTION, 8'd9, 8'd9, BTN_NONE, MOD_NONE);
    send_event(mre_pkg::KIND_MOTION, 8'd12, 8'd34, BTN_RIGHT, MOD_ALT);
    send_event(mre_pkg::KIND_RELEASE, 8'd98, 8'd8, BTN_MIDDLE, MOD_NONE);
    send_event(mre_pkg::KIND_PRESS, 8'd255, 8'd255, BTN_NONE, MOD_ALL);
  endtask

  task automatic test_any_urxvt();
    write_register(mre_pkg::REG_TRACKING_MODE, mre_pkg::TRK_ANY);
    write_register(mre_pkg::REG_REPORT_ENCODING, mre_pkg::ENC_URXVT);
    // column 255 gives a one-based 256, printed as 0
    send_event(mre_pkg::KIND_MOTION, 8'd254, 8'd255, BTN_NONE, MOD_NONE);
    send_event(mre_pkg::KIND_RELEASE, 8'd0, 8'd9, WHEEL_DOWN,
               MOD_CTRL | MOD_SHIFT | MOD_ALT);
    send_event(mre_pkg::KIND_PRESS, 8'd222, 8'd222, BTN_LEFT, MOD_NONE);
  endtask

  task automatic test_unknown_modes();
    write_register(mre_pkg::REG_TRACKING_MODE, TRK_UNKNOWN_LO);
    send_event(mre_pkg::KIND_PRESS, 8'd1, 8'd2, BTN_LEFT, MOD_NONE);
    write_register(mre_pkg::REG_TRACKING_MODE, TRK_UNKNOWN_HI);
    send_event(mre_pkg::KIND_PRESS, 8'd1, 8'd2, BTN_LEFT, MOD_NONE);
    write_register(mre_pkg::REG_TRACKING_MODE, mre_pkg::TRK_NONE);
    send_event(mre_pkg::KIND_PRESS, 8'd1, 8'd2, BTN_LEFT, MOD_NONE);
  endtask

  function automatic logic [7:0] pick_coord();
    logic [7:0] edges[6] = '{8'd0, 8'd1, 8'd222, 8'd223, 8'd254, 8'd255};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_random_traffic();
    logic [2:0] modes[8] = '{mre_pkg::TRK_NORMAL, mre_pkg::TRK_BUTTON, mre_pkg::TRK_ANY,
                             mre_pkg::TRK_X10, mre_pkg::TRK_ANY, mre_pkg::TRK_BUTTON,
                             mre_pkg::TRK_NORMAL, mre_pkg::TRK_ANY};
    logic [1:0] kind;
    int phase;
    phase = 0;
    while (phase < RANDOM_PHASES) begin
      in_idle_on  = (phase % 3 != 2);
      out_idle_on = (phase % 4 != 3);
      if (phase == 5) begin
        write_register(mre_pkg::REG_TRACKING_MODE, 3'($urandom_range(0, 7)));
      end else begin
        write_register(mre_pkg::REG_TRACKING_MODE, modes[phase % 8]);
      end
      write_register(mre_pkg::REG_REPORT_ENCODING,
                     {1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))});
      for (int i = 0; i < 16; i++) begin
        kind = ($urandom_range(0, 15) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
        send_event(kind, pick_coord(), pick_coord(), 3'($urandom_range(0, 7)),
                   4'($urandom_range(0, 15)));
        // hold the sender once until the output has caught up
        if (phase == 1 && i == 7) wait_reports_done();
      end
      phase++;
    end
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    event_kind <= mre_pkg::KIND_PRESS;
    row        <= '0;
    column     <= '0;
    button     <= BTN_NONE;
    modifiers  <= MOD_NONE;
    mode_setting     = mre_pkg::TRK_NONE;
    encoding_setting = mre_pkg::ENC_SIMPLE;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_normal_simple();
    test_x10_utf8();
    test_motion_sgr();
    test_any_urxvt();
    test_unknown_modes();
    test_random_traffic();
    wait_reports_done();

    $display("%0d events sent, %0d reported, %0d report bytes checked", events_sent,
             events_reported, bytes_checked);
    $display("covered all tracking modes and encodings with random input gaps and output stalls");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
